FILE: design/dr_pkg.sv
// Shared types and constants of the dead reckoning pose integrator.
// Holds the queue item layouts and the CORDIC arctangent table; no dependencies.
package dr_pkg;

  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned XW = 34;
  localparam int unsigned ZW = 33;
  localparam logic signed [16:0] KINV_Q16 = 17'sd39797;
  localparam logic signed [XW-1:0] ROUND_BIAS = XW'(32768);
  localparam logic signed [XW-1:0] POS_MAX = XW'(64'sd2147483647);
  localparam logic signed [XW-1:0] POS_MIN = -XW'(64'sd2147483648);

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] z;
    logic [15:0]        heading;
  } step_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
  } pose_t;

  function automatic logic [31:0] atan_angle(input int unsigned idx);
    logic [31:0] a;
    unique case (idx)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: design/dr_fifo.sv
// Small register based queue with push/full and pop/empty sides.
// Generic in width and depth; no package dependency.
module dr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/dr_front.sv
// Front end: accepts odometry steps, updates the heading and folds the angle.
// Produces step_t items for the middle queue; uses dr_pkg.
module dr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic signed [15:0]  step_distance_i,
  input  logic signed [15:0]  heading_change_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output dr_pkg::step_t       q_item_o
);
  import dr_pkg::*;

  logic [15:0]        heading_q, heading_d;
  logic signed [32:0] prod;
  logic               fold;
  logic               accept;

  assign accept    = push_i && !q_full_i;
  assign heading_d = heading_q + heading_change_i;
  assign prod      = step_distance_i * KINV_Q16;
  assign fold      = heading_d[15] ^ heading_d[14];

  always_comb begin
    q_item_o.heading = heading_d;
    q_item_o.x0      = fold ? 32'(-prod) : prod[31:0];
    q_item_o.z       = {heading_d[15] ^ fold, heading_d[14:0], 16'h0000};
  end

  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
    end else if (accept) begin
      heading_q <= heading_d;
    end
  end

endmodule

FILE: design/dr_back.sv
// Back end: pipelined CORDIC rotation, rounding and saturating position sum.
// Pulls step_t items from the middle queue and pushes pose_t; uses dr_pkg.
module dr_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dr_pkg::step_t q_item_i,
  input  logic          q_empty_i,
  output logic          q_pop_o,
  input  logic          out_full_i,
  output logic          out_push_o,
  output dr_pkg::pose_t out_item_o
);
  import dr_pkg::*;

  localparam int unsigned N = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  logic signed [XW-1:0] src_x [N];
  logic signed [XW-1:0] src_y [N];
  logic signed [ZW-1:0] src_z [N];
  logic [15:0]          src_h [N];
  logic signed [XW-1:0] nxt_x [N];
  logic signed [XW-1:0] nxt_y [N];
  logic signed [ZW-1:0] nxt_z [N];
  logic signed [XW-1:0] x_q [N];
  logic signed [XW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];
  logic [15:0]          h_q [N];
  logic [N-1:0]         vld_q;
  logic                 adv;

  logic signed [31:0]   acc_x_q, acc_x_d;
  logic signed [31:0]   acc_y_q, acc_y_d;
  logic signed [XW-1:0] rnd_x, rnd_y, sum_x, sum_y;

  assign adv     = !out_full_i;
  assign q_pop_o = adv && !q_empty_i;

  always_comb begin
    src_x[0] = {{(XW-32){q_item_i.x0[31]}}, q_item_i.x0};
    src_y[0] = '0;
    src_z[0] = {{(ZW-32){q_item_i.z[31]}}, q_item_i.z};
    src_h[0] = q_item_i.heading;
    for (int k = 1; k < N; k++) begin
      src_x[k] = x_q[k-1];
      src_y[k] = y_q[k-1];
      src_z[k] = z_q[k-1];
      src_h[k] = h_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (!src_z[k][ZW-1]) begin
        nxt_x[k] = src_x[k] - (src_y[k] >>> k);
        nxt_y[k] = src_y[k] + (src_x[k] >>> k);
        nxt_z[k] = src_z[k] - $signed({1'b0, atan_angle(k)});
      end else begin
        nxt_x[k] = src_x[k] + (src_y[k] >>> k);
        nxt_y[k] = src_y[k] - (src_x[k] >>> k);
        nxt_z[k] = src_z[k] + $signed({1'b0, atan_angle(k)});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[N-2:0], !q_empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        x_q[k] <= nxt_x[k];
        y_q[k] <= nxt_y[k];
        z_q[k] <= nxt_z[k];
        h_q[k] <= src_h[k];
      end
    end
  end

  assign rnd_x = (x_q[N-1] + ROUND_BIAS) >>> 16;
  assign rnd_y = (y_q[N-1] + ROUND_BIAS) >>> 16;
  assign sum_x = {{(XW-32){acc_x_q[31]}}, acc_x_q} + rnd_x;
  assign sum_y = {{(XW-32){acc_y_q[31]}}, acc_y_q} + rnd_y;

  always_comb begin
    priority if (sum_x > POS_MAX) begin
      acc_x_d = POS_MAX[31:0];
    end else if (sum_x < POS_MIN) begin
      acc_x_d = POS_MIN[31:0];
    end else begin
      acc_x_d = sum_x[31:0];
    end
    priority if (sum_y > POS_MAX) begin
      acc_y_d = POS_MAX[31:0];
    end else if (sum_y < POS_MIN) begin
      acc_y_d = POS_MIN[31:0];
    end else begin
      acc_y_d = sum_y[31:0];
    end
  end

  assign out_push_o         = adv && vld_q[N-1];
  assign out_item_o.pos_x   = acc_x_d;
  assign out_item_o.pos_y   = acc_y_d;
  assign out_item_o.heading = h_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (out_push_o) begin
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
    end
  end

endmodule

FILE: design/dead_reckoning_pose_integrator.sv
// Top level of the dead reckoning pose integrator.
// Instantiates dr_front, dr_back and two dr_fifo queues; uses dr_pkg.
//
//   channel  direction  handshake    fields
//   step     in         push / full  step_distance_i, heading_change_i
//   pose     out        pop / empty  pos_x_o, pos_y_o, heading_o
//
// One step is accepted per cycle while the step queue is not full; its pose is on the
// result ports once it has passed the step queue, the CORDIC stage registers and the pose queue.
// The CORDIC back end is one pipeline stage per iteration (24 at most).
// Reset clears the heading and position accumulators and empties both queues.
// When the pose queue is full the whole CORDIC pipeline holds and the step
// queue fills; full rises once it holds two steps.
module dead_reckoning_pose_integrator #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] step_distance_i,
  input  logic signed [15:0] heading_change_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [15:0]        heading_o
);
  import dr_pkg::*;

  step_t mid_in, mid_out;
  pose_t pose_in, pose_out;
  logic  mid_push, mid_full, mid_pop, mid_empty;
  logic  out_push, out_full;

  dr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .step_distance_i  (step_distance_i),
    .heading_change_i (heading_change_i),
    .q_full_i         (mid_full),
    .q_push_o         (mid_push),
    .q_item_o         (mid_in)
  );

  dr_fifo #(
    .WIDTH ($bits(step_t)),
    .DEPTH (2)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  dr_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_item_i   (mid_out),
    .q_empty_i  (mid_empty),
    .q_pop_o    (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_item_o (pose_in)
  );

  dr_fifo #(
    .WIDTH ($bits(pose_t)),
    .DEPTH (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (pose_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (pose_out),
    .empty_o (empty)
  );

  assign full      = mid_full;
  assign pos_x_o   = pose_out.pos_x;
  assign pos_y_o   = pose_out.pos_y;
  assign heading_o = pose_out.heading;

endmodule

FILE: test/dead_reckoning_pose_integrator_test.sv
// Self-checking testbench for the dead reckoning pose integrator.
// Drives steps through the push/full queue, predicts each pose in a scoreboard class and
// checks every popped pose; depends on dr_pkg and dead_reckoning_pose_integrator.
module dead_reckoning_pose_integrator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dr_pkg::pose_t;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned LUT_DEPTH = 24;
  localparam longint KINV_GAIN = 39797;
  localparam longint ATAN_LUT [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };
  localparam int unsigned RANDOM_STEPS = 1600;
  localparam int unsigned RAIL_STEPS_UP = 30;
  localparam int unsigned RAIL_STEPS_DOWN = 60;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_PCT = 14;
  localparam int unsigned DRAIN_CYCLES = CORDIC_STEPS + 10;
  localparam longint CYCLE_LIMIT = 2000000;

  class pose_scoreboard;
    logic signed [31:0] x_q;
    logic signed [31:0] y_q;
    logic [15:0]        heading_q;
    pose_t              poses_due[$];
    int unsigned        mismatches;

    function void clear();
      x_q = '0;
      y_q = '0;
      heading_q = '0;
      poses_due.delete();
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return poses_due.size();
    endfunction

    function void flag(string what, longint expd, longint got);
      mismatches++;
      $error("%s: expected %0d, got %0d", what, expd, got);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_step(logic signed [15:0] dist_in, logic [15:0] dturn);
      longint      x;
      longint      y;
      longint      z;
      longint      xs;
      longint      ys;
      logic [31:0] zu;
      pose_t       p;
      heading_q = heading_q + dturn;
      zu = {heading_q, 16'h0000};
      x = longint'(dist_in) * KINV_GAIN;
      y = 0;
      if (((zu + 32'h4000_0000) & 32'h8000_0000) != 32'h0) begin
        x = -x;
        zu = zu + 32'h8000_0000;
      end
      z = longint'($signed(zu));
      for (int i = 0; i < CORDIC_STEPS && i < LUT_DEPTH; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_LUT[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_LUT[i];
        end
      end
      x = (x + 32768) >>> 16;
      y = (y + 32768) >>> 16;
      x = clamp32(longint'(x_q) + x);
      y = clamp32(longint'(y_q) + y);
      x_q = x[31:0];
      y_q = y[31:0];
      p.pos_x = x_q;
      p.pos_y = y_q;
      p.heading = heading_q;
      poses_due.push_back(p);
    endfunction

    function void check_pose(logic signed [31:0] px, logic signed [31:0] py, logic [15:0] hd);
      pose_t p;
      if (poses_due.size() == 0) begin
        mismatches++;
        $error("pose popped with no step pending: x %0d, y %0d, heading %0d", px, py, hd);
      end else begin
        p = poses_due.pop_front();
        if (px !== p.pos_x) flag("pos_x", longint'(p.pos_x), longint'(px));
        if (py !== p.pos_y) flag("pos_y", longint'(p.pos_y), longint'(py));
        if (hd !== p.heading) flag("heading", longint'(p.heading), longint'(hd));
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic signed [15:0] step_distance_i;
  logic signed [15:0] heading_change_i;
  logic               empty;
  logic               pop;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic [15:0]        heading_o;

  pose_scoreboard sb = new();
  bit             tx_steady;
  bit             rx_steady;
  bit             hold_req;
  logic [15:0]    cur_heading;
  longint         cycle_count;

  dead_reckoning_pose_integrator #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .step_distance_i (step_distance_i),
    .heading_change_i(heading_change_i),
    .empty           (empty),
    .pop             (pop),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .heading_o       (heading_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_step(step_distance_i, heading_change_i);
      if (pop && !empty) sb.check_pose(pos_x_o, pos_y_o, heading_o);
    end
  end

  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        pop <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
      end else begin
        pop <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk_i);
      end
    end
  end

  task automatic send_step(input logic signed [15:0] dist_in, input logic [15:0] dturn);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    step_distance_i <= dist_in;
    heading_change_i <= dturn;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    cur_heading = cur_heading + dturn;
  endtask

  task automatic wait_all_poses();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic signed [15:0] step_dist;
    logic [15:0]        dturn;
    rst_ni = 1'b0;
    push <= 1'b0;
    step_distance_i <= '0;
    heading_change_i <= '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req = 1'b0;
    cur_heading = '0;
    sb.clear();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_step(16'sd0, 16'h0000);
    send_step(16'sd32767, 16'h0000);
    send_step(-16'sd32768, 16'h0000);
    send_step(16'sd1, 16'h0000);
    send_step(-16'sd1, 16'h0000);
    send_step(16'sd32767, 16'h4000);
    send_step(16'sd32767, 16'h4000);
    send_step(16'sd32767, 16'h4000);
    send_step(16'sd32767, 16'h4000);
    send_step(16'sd32767, 16'h3fff);
    send_step(-16'sd32768, 16'h0001);
    send_step(16'sd32767, 16'h7fff);
    send_step(16'sd32767, 16'h0001);
    send_step(16'sd32767, 16'h8000);
    send_step(16'sd32767, 16'hffff);
    send_step(-16'sd32768, 16'h7fff);
    send_step(16'sd12345, 16'hc000);
    send_step(-16'sd77, 16'h2000);
    send_step(16'sd32767, 16'h0000);
    send_step(16'sd1000, 16'hdfff);

    for (int n = 0; n < RANDOM_STEPS; n++) begin
      if (n == 500) begin
        tx_steady = 1'b1;
        hold_req = 1'b1;
      end
      if (n == 800) tx_steady = 1'b0;
      if (n == 1000) wait_all_poses();
      if (n == 1200) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      if (n == 1500) begin
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          step_dist = 16'($urandom);
          dturn = 16'($urandom);
        end
        6, 7: begin
          step_dist = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          dturn = 16'($urandom);
        end
        8: begin
          step_dist = 16'($urandom);
          dturn = 16'($urandom_range(8)) - 16'd4;
        end
        default: begin
          step_dist = 16'($urandom);
          dturn = {2'($urandom_range(3)), 14'h0000} - cur_heading
                  + 16'($urandom_range(2)) - 16'd1;
        end
      endcase
      send_step(step_dist, dturn);
    end

    // Run diagonally at full speed, then straight back past the start at full speed.
    send_step(16'sd32767, 16'h2000 - cur_heading);
    for (int n = 0; n < RAIL_STEPS_UP; n++) send_step(16'sd32767, 16'h0000);
    for (int n = 0; n < RAIL_STEPS_DOWN; n++) send_step(-16'sd32768, 16'h0000);
    for (int n = 0; n < 100; n++) begin
      step_dist = 16'($urandom);
      dturn = 16'($urandom);
      send_step(step_dist, dturn);
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
